// ===== src/tpma_pkg.sv =====
`timescale 1ns / 1ps

package tpma_pkg;

	localparam int AVG_DEPTH = 16;
	localparam int IDX_W     = $clog2(AVG_DEPTH);

	localparam int CLK_W     = 27;
	localparam int CAP_W     = 32;
	localparam int OP_W      = 2;
	localparam int FREQ_W    = 35;
	localparam int FRAC_W    = 8;

	localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(80000000);

	// numerator widths: clock*256 and clock*AVG_DEPTH*256
	localparam int AVG_MUL_W = CLK_W + $clog2(AVG_DEPTH);
	localparam int DIV_W     = AVG_MUL_W + FRAC_W;
	localparam int CNT_W     = $clog2(DIV_W);

	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_EDGE    = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

endpackage

// ===== src/tpma_if.sv =====
`timescale 1ns / 1ps

interface tpma_item_if import tpma_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [CAP_W-1:0] capture_value;

	modport source (output valid, output operation, output capture_value, input ready);
	modport sink (input valid, input operation, input capture_value, output ready);
endinterface

interface tpma_result_if import tpma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              tach_alive;
	logic [FREQ_W-1:0] frequency_raw;
	logic [FREQ_W-1:0] frequency_avg;
	logic              restart_timeout;

	modport source (output valid, output tach_alive, output frequency_raw,
		output frequency_avg, output restart_timeout, input ready);
	modport sink (input valid, input tach_alive, input frequency_raw,
		input frequency_avg, input restart_timeout, output ready);
endinterface

interface tpma_cfg_if import tpma_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CLK_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/tach_period_moving_average_core.sv =====
`timescale 1ns / 1ps

// Tach period capture with a moving-average frequency. Each transaction on item
// is an edge capture (down-counting timer value), a timeout or a clear; each
// produces exactly one status transaction on result. An edge with a non-zero
// period runs one bit-serial restoring divider, which computes clock*256/period
// and then clock*AVG_DEPTH*256/sum, one quotient bit per cycle. The average
// division is skipped when the sum is zero. Zero-period edges, timeouts and
// clears never enter either of the divider states. One item
// is in flight at a time; a finished result waits in an output register while
// the next item is accepted. cfg writes the timer clock in hertz (reset
// 80000000) and is always ready; write it only while idle.
module tach_period_moving_average_core import tpma_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	tpma_item_if.sink    item,
	tpma_result_if.source result,
	tpma_cfg_if.sink     cfg
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_UPDATE  = 5'b00010,
		ST_DIV_RAW = 5'b00100,
		ST_DIV_AVG = 5'b01000,
		ST_WRITE   = 5'b10000
	} state_t;

	state_t state_q;

	logic [CLK_W-1:0]  clock_q;
	logic [CAP_W-1:0]  last_q;
	logic [CAP_W-1:0]  period_q;
	logic [CAP_W-1:0]  sum_q;
	logic [CAP_W-1:0]  ring_q [AVG_DEPTH];
	logic [AVG_DEPTH-1:0] ring_vld_q;
	logic [IDX_W-1:0]  idx_q;
	logic              alive_q;
	logic [FREQ_W-1:0] raw_q;
	logic [FREQ_W-1:0] avg_q;
	logic              restart_q;

	logic [DIV_W-1:0]  num_q;
	logic [CAP_W-1:0]  rem_q;
	logic [CAP_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              res_vld_q;
	logic              res_alive_q;
	logic [FREQ_W-1:0] res_raw_q;
	logic [FREQ_W-1:0] res_avg_q;
	logic              res_restart_q;

	logic              item_acc;
	logic [CAP_W-1:0]  ring_rd;
	logic [CAP_W-1:0]  sum_n;
	logic [CAP_W:0]    trial;
	logic              ge;
	logic [CAP_W-1:0]  rem_n;
	logic [DIV_W-1:0]  num_n;
	logic [DIV_W-1:0]  num_raw;
	logic [DIV_W-1:0]  num_avg;
	logic [AVG_MUL_W-1:0] clk_mul;
	logic              res_load;
	logic [FREQ_W-1:0] avg_sat;

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign ring_rd = ring_vld_q[idx_q] ? ring_q[idx_q] : '0;
	assign sum_n   = sum_q - ring_rd + period_q;

	assign clk_mul = AVG_MUL_W'(clock_q) * AVG_MUL_W'(AVG_DEPTH);
	assign num_raw = DIV_W'({clock_q, {FRAC_W{1'b0}}});
	assign num_avg = {clk_mul, {FRAC_W{1'b0}}};

	// one restoring step: bring down the next numerator bit, subtract if it fits
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign rem_n = ge ? CAP_W'(trial - {1'b0, den_q}) : trial[CAP_W-1:0];
	assign num_n = {num_q[DIV_W-2:0], ge};

	assign avg_sat = (|num_n[DIV_W-1:FREQ_W]) ? FREQ_MAX : num_n[FREQ_W-1:0];

	assign res_load = (state_q == ST_WRITE) && (!res_vld_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
		end else if (cfg.valid) begin
			clock_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_q     <= '0;
			sum_q      <= '0;
			ring_vld_q <= '0;
			idx_q      <= '0;
			alive_q    <= 1'b0;
			raw_q      <= '0;
			avg_q      <= '0;
			restart_q  <= 1'b0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						restart_q <= 1'b0;
						case (op_t'(item.operation))
							OP_EDGE: begin
								last_q  <= item.capture_value;
								state_q <= ST_UPDATE;
							end
							OP_TIMEOUT: begin
								alive_q <= 1'b0;
								raw_q   <= '0;
								avg_q   <= '0;
								state_q <= ST_WRITE;
							end
							OP_CLEAR: begin
								last_q     <= '0;
								sum_q      <= '0;
								ring_vld_q <= '0;
								idx_q      <= '0;
								alive_q    <= 1'b0;
								raw_q      <= '0;
								avg_q      <= '0;
								state_q    <= ST_WRITE;
							end
							default: begin
								state_q <= ST_WRITE;
							end
						endcase
					end
				end
				ST_UPDATE: begin
					if (period_q == '0) begin
						state_q <= ST_WRITE;
					end else begin
						sum_q             <= sum_n;
						ring_vld_q[idx_q] <= 1'b1;
						idx_q     <= (idx_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_q + 1'b1;
						alive_q   <= 1'b1;
						restart_q <= 1'b1;
						cnt_q     <= CNT_W'(DIV_W - 1);
						state_q   <= ST_DIV_RAW;
					end
				end
				ST_DIV_RAW: begin
					if (cnt_q == '0) begin
						raw_q <= num_n[FREQ_W-1:0];
						if (sum_q != '0) begin
							cnt_q   <= CNT_W'(DIV_W - 1);
							state_q <= ST_DIV_AVG;
						end else begin
							state_q <= ST_WRITE;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV_AVG: begin
					if (cnt_q == '0) begin
						avg_q   <= avg_sat;
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_WRITE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: period, ring entries and divider datapath
	always_ff @(posedge clk) begin
		if (item_acc) begin
			period_q <= last_q - item.capture_value;
		end
		if (state_q == ST_UPDATE && period_q != '0) begin
			ring_q[idx_q] <= period_q;
			num_q         <= num_raw;
			den_q         <= period_q;
			rem_q         <= '0;
		end else if (state_q == ST_DIV_RAW && cnt_q == '0) begin
			num_q <= num_avg;
			den_q <= sum_q;
			rem_q <= '0;
		end else if (state_q == ST_DIV_RAW || state_q == ST_DIV_AVG) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_alive_q   <= alive_q;
			res_raw_q     <= raw_q;
			res_avg_q     <= avg_q;
			res_restart_q <= restart_q;
		end
	end

	assign result.valid           = res_vld_q;
	assign result.tach_alive      = res_alive_q;
	assign result.frequency_raw   = res_raw_q;
	assign result.frequency_avg   = res_avg_q;
	assign result.restart_timeout = res_restart_q;

`ifndef SYNTH
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_RAW || state_q == ST_DIV_AVG) |-> den_q != '0)
		else $error("divider running with zero divisor");

	a_restart_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_restart_q) |-> res_alive_q)
		else $error("timeout restart without alive flag");

	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.operation == OP_CLEAR) |=> (sum_q == '0 && ring_vld_q == '0))
		else $error("clear left period data behind");

	a_sum_has_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_q != '0) |-> (ring_vld_q != '0))
		else $error("non-zero sum with an empty ring");
`endif

endmodule

// ===== test/tb_tach_period_moving_average_core.sv =====
`timescale 1ns / 1ps

module tb_tach_period_moving_average_core;
	import tpma_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int GAP_MAX      = 18;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 100;
	localparam int QUIET_LIMIT  = 5000;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [CAP_W-1:0] cap;
	} tach_event_t;

	typedef struct packed {
		logic              alive;
		logic [FREQ_W-1:0] raw;
		logic [FREQ_W-1:0] avg;
		logic              restart;
	} tach_status_t;

	logic clk;
	logic arst_n;

	tpma_item_if   item_ch();
	tpma_result_if result_ch();
	tpma_cfg_if    cfg_ch();

	tach_period_moving_average_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the tach state
	logic [CLK_W-1:0]  timer_hz = CLOCK_RESET;
	logic [CAP_W-1:0]  last_cap = '0;
	logic [CAP_W-1:0]  period_ring [AVG_DEPTH] = '{default: '0};
	logic [CAP_W-1:0]  period_sum = '0;
	logic [IDX_W-1:0]  ring_pos = '0;
	logic              alive = 1'b0;
	logic [FREQ_W-1:0] freq_raw = '0;
	logic [FREQ_W-1:0] freq_avg = '0;

	tach_event_t  event_backlog [$];
	tach_status_t status_due [$];
	logic [CAP_W-1:0] timer_trace = '0;

	bit item_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int idle_pct = 0;

	int n_events = 0;
	int n_periods = 0;
	int n_timeouts = 0;
	int n_clears = 0;
	int n_checked = 0;
	int clock_settings = 0;
	int mismatches = 0;

	function automatic void log_failure(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", what);
	endfunction

	function automatic void predict_tach_status(input logic [OP_W-1:0] op,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] period;
		logic [63:0]      num;
		logic [63:0]      quot;
		tach_status_t     s;
		s.restart = 1'b0;
		n_events++;
		case (op)
			OP_EDGE: begin
				period = last_cap - cap;
				last_cap = cap;
				if (period != '0) begin
					period_sum = period_sum - period_ring[ring_pos] + period;
					period_ring[ring_pos] = period;
					ring_pos = (ring_pos == IDX_W'(AVG_DEPTH - 1)) ? '0 : ring_pos + 1'b1;
					alive = 1'b1;
					num = 64'(timer_hz) << FRAC_W;
					quot = num / 64'(period);
					freq_raw = quot[FREQ_W-1:0];
					if (period_sum != '0) begin
						num = (64'(timer_hz) * 64'(AVG_DEPTH)) << FRAC_W;
						quot = num / 64'(period_sum);
						freq_avg = (quot > 64'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
					end
					s.restart = 1'b1;
					n_periods++;
				end
			end
			OP_TIMEOUT: begin
				alive = 1'b0;
				freq_raw = '0;
				freq_avg = '0;
				n_timeouts++;
			end
			OP_CLEAR: begin
				foreach (period_ring[i])
					period_ring[i] = '0;
				last_cap = '0;
				period_sum = '0;
				ring_pos = '0;
				alive = 1'b0;
				freq_raw = '0;
				freq_avg = '0;
				n_clears++;
			end
			default: ;
		endcase
		s.alive = alive;
		s.raw = freq_raw;
		s.avg = freq_avg;
		status_due.push_back(s);
	endfunction

	function automatic void queue_event(input logic [OP_W-1:0] op,
			input logic [CAP_W-1:0] cap);
		tach_event_t e;
		e.op = op;
		e.cap = cap;
		event_backlog.push_back(e);
		if (op == OP_EDGE)
			timer_trace = cap;
		else if (op == OP_CLEAR)
			timer_trace = '0;
	endfunction

	// mostly a steadily counting timer, with dead tach, wipes and junk mixed in
	function automatic void queue_random_events(input int count);
		int pick;
		logic [CAP_W-1:0] span;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				queue_event(OP_TIMEOUT, $urandom);
			else if (pick < 6)
				queue_event(OP_CLEAR, $urandom);
			else if (pick < 7)
				queue_event(OP_UNUSED, $urandom);
			else if (pick < 10)
				queue_event(OP_EDGE, timer_trace);
			else if (pick < 14)
				queue_event(OP_EDGE, $urandom);
			else begin
				case ($urandom_range(0, 3))
					0: span = $urandom_range(1, 300);
					1: span = $urandom_range(2000, 400000);
					2: span = 32'd1 << $urandom_range(0, 31);
					default: span = $urandom;
				endcase
				queue_event(OP_EDGE, timer_trace - span);
			end
		end
	endfunction

	task automatic wait_until_idle();
		while (event_backlog.size() != 0 || item_ch.valid || status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_timer_clock(input logic [CLK_W-1:0] hz);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= hz;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		timer_hz = hz;
		clock_settings++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			predict_tach_status(item_ch.operation, item_ch.capture_value);
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : event_driver
		tach_event_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.operation <= OP_EDGE;
			item_ch.capture_value <= '0;
		end else if (item_ch.valid && !item_taken) begin
			// hold the offered transaction
		end else if (send_gap > 0) begin
			send_gap--;
			item_ch.valid <= 1'b0;
		end else if (event_backlog.size() != 0) begin
			nxt = event_backlog.pop_front();
			item_ch.valid <= 1'b1;
			item_ch.operation <= nxt.op;
			item_ch.capture_value <= nxt.cap;
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
				send_gap = $urandom_range(1, GAP_MAX);
		end else begin
			item_ch.valid <= 1'b0;
		end
		item_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = LONG_HOLD;
			hold_served = hold_requests;
		end
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
				stall_left = $urandom_range(1, GAP_MAX);
		end
	end

	always @(posedge clk) begin : status_monitor
		tach_status_t got;
		tach_status_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.alive = result_ch.tach_alive;
			got.raw = result_ch.frequency_raw;
			got.avg = result_ch.frequency_avg;
			got.restart = result_ch.restart_timeout;
			if (status_due.size() == 0) begin
				log_failure($sformatf("status with nothing pending: alive=%0b raw=%0h avg=%0h",
					got.alive, got.raw, got.avg));
			end else begin
				want = status_due.pop_front();
				n_checked++;
				if (got.alive !== want.alive || got.raw !== want.raw ||
						got.avg !== want.avg || got.restart !== want.restart)
					log_failure($sformatf(
						"status %0d exp alive=%0b raw=%0h avg=%0h restart=%0b, got %0b %0h %0h %0b",
						n_checked, want.alive, want.raw, want.avg, want.restart,
						got.alive, got.raw, got.avg, got.restart));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset clock, period extremes, zero periods, wrapped sum
		idle_pct = 20;
		queue_event(OP_TIMEOUT, '0);
		queue_event(OP_EDGE, '0);
		queue_event(OP_EDGE, 32'hFFFF_FFFF);
		queue_event(OP_EDGE, 32'hFFFF_FFFF);
		queue_event(OP_EDGE, '0);
		queue_event(OP_UNUSED, 32'hA5A5_5A5A);
		queue_event(OP_TIMEOUT, 32'hFFFF_FFFF);
		queue_event(OP_EDGE, 32'hFFFF_FF00);
		queue_event(OP_CLEAR, 32'hFFFF_FFFF);
		queue_event(OP_EDGE, 32'h8000_0000);
		queue_event(OP_EDGE, '0);
		queue_event(OP_EDGE, 32'hFFFF_FFFF);
		queue_event(OP_UNUSED, '0);
		queue_event(OP_CLEAR, '0);
		for (int k = 0; k < 6; k++)
			queue_event(OP_EDGE, timer_trace - 32'd40000);
		queue_event(OP_TIMEOUT, '0);
		queue_event(OP_EDGE, timer_trace - 32'd1000);
		wait_until_idle();

		// fastest clock; starve the result side so the input backs up
		set_timer_clock(27'd120000000);
		idle_pct = 15;
		queue_random_events(150);
		hold_requests++;
		wait_until_idle();

		set_timer_clock(27'd1);
		idle_pct = 30;
		queue_random_events(100);
		wait_until_idle();

		set_timer_clock('0);
		idle_pct = 10;
		queue_random_events(30);
		wait_until_idle();

		// pause the sender halfway until everything has drained
		set_timer_clock(CLK_W'($urandom_range(1, 120000000)));
		idle_pct = 20;
		queue_random_events(120);
		wait_until_idle();
		queue_random_events(100);
		wait_until_idle();

		set_timer_clock(CLK_W'($urandom_range(1000, 20000)));
		idle_pct = 5;
		queue_random_events(150);
		wait_until_idle();

		// full speed on both sides to finish
		idle_pct = 0;
		set_timer_clock(CLOCK_RESET);
		queue_random_events(200);
		wait_until_idle();
		repeat (SETTLE) @(posedge clk);

		if (status_due.size() != 0)
			log_failure($sformatf("%0d status transactions never arrived", status_due.size()));
		$display("covered %0d events: %0d new periods, %0d timeouts, %0d clears",
			n_events, n_periods, n_timeouts, n_clears);
		$display("timer clock set %0d times, %0d results checked, %0d mismatches",
			clock_settings, n_checked, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
